[rtl/spmf_pkg.sv]
package spmf_pkg;

  localparam int LEVELS_DEF      = 8;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int DATA_WIDTH_DEF  = 32;

  localparam int LC_W    = 4;
  localparam int PRI_W   = 8;
  localparam int WORD_W  = 32;
  localparam int LEVEL_W = 3;

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_ZERO  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    action_t            action;
    logic [PRI_W-1:0]   priority_req;
    logic [WORD_W-1:0]  payload;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic [WORD_W-1:0]   data;
    logic [LEVEL_W-1:0]  level;
  } rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic take;
    logic exec;
    logic emit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_pop;
  } stat_t;

endpackage

[rtl/spmf_ctrl.sv]
module spmf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  input  spmf_pkg::stat_t stat,
  output spmf_pkg::cmd_t  cmd
);
  import spmf_pkg::*;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (stat.is_pop) begin
          state_next = S_READ;
        end else if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_stall = 1'b1;
    cmd       = '0;
    unique case (state)
      S_IDLE: begin
        req_stall = 1'b0;
        cmd.take  = req_valid;
      end
      S_EXEC: begin
        // pushes finish here, pops issue the store read
        if (stat.is_pop) begin
          cmd.exec = 1'b1;
        end else if (out_free) begin
          cmd.exec = 1'b1;
          cmd.emit = 1'b1;
        end
      end
      S_READ: begin
        cmd.emit = out_free;
      end
      default: ;
    endcase
  end

endmodule

[rtl/spmf_dp.sv]
module spmf_dp #(
  parameter int LEVELS      = spmf_pkg::LEVELS_DEF,
  parameter int QUEUE_DEPTH = spmf_pkg::QUEUE_DEPTH_DEF,
  parameter int DATA_WIDTH  = spmf_pkg::DATA_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  input  logic [spmf_pkg::LC_W-1:0] cfg_data,
  input  spmf_pkg::req_t            req,
  input  spmf_pkg::cmd_t            cmd,
  output spmf_pkg::stat_t           stat,
  output spmf_pkg::rsp_t            rsp
);
  import spmf_pkg::*;

  localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int PW    = $clog2(QUEUE_DEPTH);
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRIES = LEVELS * QUEUE_DEPTH;
  localparam int AW    = $clog2(ENTRIES);

  logic [LC_W-1:0]       lc;
  logic [LC_W-1:0]       cfg_sat;

  action_t               action_r;
  logic [LW-1:0]         pri_r;
  logic [DATA_WIDTH-1:0] word_r;
  logic [PRI_W-1:0]      pri_clamp;

  logic [PW-1:0]         head [LEVELS];
  logic [PW-1:0]         tail [LEVELS];
  logic [CW-1:0]         fill [LEVELS];

  logic                  found;
  logic [LW-1:0]         pick;
  logic                  pop_found;
  logic [LW-1:0]         pop_lvl;

  logic                  word_zero;
  logic                  full;
  logic                  push_ok;
  logic                  pop_go;
  logic [PW-1:0]         tail_cur;
  logic [PW-1:0]         head_cur;

  logic [DATA_WIDTH-1:0] mem [ENTRIES];
  logic [DATA_WIDTH-1:0] rdata;
  logic                  mem_we;
  logic                  mem_re;
  logic [AW-1:0]         waddr;
  logic [AW-1:0]         raddr;

  status_t               push_status;

  always_comb begin
    cfg_sat = cfg_data;
    if (cfg_data == '0) begin
      cfg_sat = LC_W'(1);
    end else if (cfg_data > LC_W'(LEVELS)) begin
      cfg_sat = LC_W'(LEVELS);
    end
  end

  assign pri_clamp = (req.priority_req >= PRI_W'(lc)) ? PRI_W'(lc - LC_W'(1))
                                                       : req.priority_req;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      action_r <= req.action;
      pri_r    <= LW'(pri_clamp);
      word_r   <= DATA_WIDTH'(req.payload);
    end
  end

  // lowest-numbered non-empty level among those in use
  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (fill[i] != '0 && LC_W'(i) < lc) begin
        found = 1'b1;
        pick  = LW'(i);
      end
    end
  end

  assign word_zero = (word_r == '0);
  assign full      = (fill[pri_r] == CW'(QUEUE_DEPTH));
  assign push_ok   = cmd.exec && (action_r == ACT_PUSH) && !word_zero && !full;
  assign pop_go    = cmd.exec && (action_r == ACT_POP) && found;
  assign tail_cur  = tail[pri_r];
  assign head_cur  = head[pick];

  always_comb begin
    if (word_zero) begin
      push_status = ST_ZERO;
    end else if (full) begin
      push_status = ST_FULL;
    end else begin
      push_status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lc <= LC_W'(LEVELS);
      for (int i = 0; i < LEVELS; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
        fill[i] <= '0;
      end
    end else begin
      if (cfg_valid) lc <= cfg_sat;
      if (push_ok) begin
        tail[pri_r] <= (tail_cur == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_cur + PW'(1);
        fill[pri_r] <= fill[pri_r] + CW'(1);
      end
      if (pop_go) begin
        head[pick] <= (head_cur == PW'(QUEUE_DEPTH - 1)) ? '0 : head_cur + PW'(1);
        fill[pick] <= fill[pick] - CW'(1);
      end
    end
  end

  assign mem_we = push_ok;
  assign mem_re = cmd.exec && (action_r == ACT_POP);
  assign waddr  = AW'(pri_r) * AW'(QUEUE_DEPTH) + AW'(tail_cur);
  assign raddr  = AW'(pick) * AW'(QUEUE_DEPTH) + AW'(head_cur);

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= word_r;
    if (mem_re) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      pop_found <= found;
      pop_lvl   <= pick;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (action_r == ACT_POP) begin
        rsp.status <= pop_found ? ST_OK : ST_EMPTY;
        rsp.data   <= pop_found ? WORD_W'(rdata) : '0;
        rsp.level  <= pop_found ? LEVEL_W'(pop_lvl) : '0;
      end else begin
        rsp.status <= push_status;
        rsp.data   <= '0;
        rsp.level  <= (push_status == ST_OK) ? LEVEL_W'(pri_r) : '0;
      end
    end
  end

  assign stat.is_pop = (action_r == ACT_POP);

endmodule

[rtl/strict_priority_multi_fifo_core.sv]
// Channel   Signals                          Moves
// req       req_valid, req_stall, req        push or pop request item
// rsp       rsp_valid, rsp_stall, rsp        status, popped word, level
// cfg       cfg_valid, cfg_ready, cfg_data   level_count write, always taken
//
// A push runs IDLE, EXEC, a pop also READ (registered store read), plus rsp stalls.
// One item is in flight at a time; a new item is taken while a result waits on rsp.
// Synchronous reset empties all levels and sets level_count to LEVELS.
// The entry store itself is not cleared.
module strict_priority_multi_fifo_core #(
  parameter int LEVELS      = spmf_pkg::LEVELS_DEF,
  parameter int QUEUE_DEPTH = spmf_pkg::QUEUE_DEPTH_DEF,
  parameter int DATA_WIDTH  = spmf_pkg::DATA_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  spmf_pkg::req_t            req,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output spmf_pkg::rsp_t            rsp,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [spmf_pkg::LC_W-1:0] cfg_data
);
  import spmf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  spmf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  spmf_dp #(
    .LEVELS      (LEVELS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp       (rsp)
  );

endmodule

[tb/strict_priority_multi_fifo_core_test.sv]
module strict_priority_multi_fifo_core_test;
  import spmf_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH_DEF;
  localparam int NLEV = LEVELS_DEF;
  localparam int LIMIT_CYCLES = 200000;

  logic clk;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [LC_W-1:0] cfg_data = '0;

  req_t pending_reqs[$];
  rsp_t expected_rsp[$];
  logic [LC_W-1:0] pending_level_writes[$];

  // queue model
  logic [WORD_W-1:0] slot_word [NLEV][DEPTH];
  int head_pos [NLEV];
  int tail_pos [NLEV];
  int fill [NLEV];
  int level_cnt = NLEV;

  int errors = 0;
  int cycle_count = 0;
  bit quiet_run = 1'b0;

  strict_priority_multi_fifo_core uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic rsp_t queue_step(req_t r);
    rsp_t o;
    int pri;
    int i;
    bit found;
    o.status = ST_OK;
    o.data = '0;
    o.level = '0;
    found = 1'b0;
    if (r.action == ACT_PUSH) begin
      pri = (int'(r.priority_req) >= level_cnt) ? level_cnt - 1 : int'(r.priority_req);
      if (r.payload == '0) begin
        o.status = ST_ZERO;
      end else if (fill[pri] >= DEPTH) begin
        o.status = ST_FULL;
      end else begin
        slot_word[pri][tail_pos[pri]] = r.payload;
        tail_pos[pri] = (tail_pos[pri] + 1) % DEPTH;
        fill[pri]++;
        o.level = pri[LEVEL_W-1:0];
      end
    end else begin
      o.status = ST_EMPTY;
      for (i = 0; i < level_cnt; i++) begin
        if (!found && fill[i] != 0) begin
          found = 1'b1;
          o.data = slot_word[i][head_pos[i]];
          head_pos[i] = (head_pos[i] + 1) % DEPTH;
          fill[i]--;
          o.level = i[LEVEL_W-1:0];
          o.status = ST_OK;
        end
      end
    end
    return o;
  endfunction

  function automatic req_t make_push(int prio, logic [WORD_W-1:0] word);
    req_t r;
    r.action = ACT_PUSH;
    r.priority_req = prio[PRI_W-1:0];
    r.payload = word;
    return r;
  endfunction

  function automatic req_t make_pop();
    req_t r;
    r.action = ACT_POP;
    r.priority_req = PRI_W'($urandom_range(255));
    r.payload = $urandom();
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    logic [WORD_W-1:0] w;
    w = $urandom();
    if ($urandom_range(99) < 5) begin
      w = '0;
    end else if (w == '0) begin
      w = 1;
    end
    return w;
  endfunction

  // bursts of pushes and pops; some bursts hammer a single level with pushes
  task automatic queue_random(int n);
    int mode;
    int len;
    int k;
    int lvl;
    int push_pct;
    while (n > 0) begin
      mode = $urandom_range(3);
      len = $urandom_range(24, 4);
      lvl = $urandom_range(NLEV - 1);
      push_pct = (mode == 0) ? 85 : (mode == 1) ? 25 : 60;
      for (k = 0; k < len && n > 0; k++) begin
        if (mode == 3) begin
          pending_reqs.push_back(make_push(lvl, rand_word()));
        end else if ($urandom_range(99) < push_pct) begin
          if ($urandom_range(99) < 70)
            pending_reqs.push_back(make_push($urandom_range(level_cnt), rand_word()));
          else
            pending_reqs.push_back(make_push($urandom_range(255), rand_word()));
        end else begin
          pending_reqs.push_back(make_pop());
        end
        n--;
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_reqs.size() != 0 || expected_rsp.size() != 0 || req_valid ||
           pending_level_writes.size() != 0 || cfg_valid)
      @(negedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall)
        expected_rsp.push_back(queue_step(req));
      if (!req_valid || !req_stall) begin
        if (pending_reqs.size() != 0 && (quiet_run || $urandom_range(99) >= 15)) begin
          req_valid <= 1'b1;
          req <= pending_reqs.pop_front();
        end else begin
          req_valid <= 1'b0;
        end
      end
      if (cfg_valid && cfg_ready) begin
        level_cnt = (cfg_data == 0) ? 1 : (cfg_data > NLEV) ? NLEV : int'(cfg_data);
        cfg_valid <= 1'b0;
      end else if (!cfg_valid && pending_level_writes.size() != 0) begin
        cfg_valid <= 1'b1;
        cfg_data <= pending_level_writes.pop_front();
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp.size() == 0) begin
          $display("%0t: unexpected item status %0d data %h level %0d", $time,
                   rsp.status, rsp.data, rsp.level);
          errors++;
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, rsp.status);
            errors++;
          end
          if (rsp.data !== want.data) begin
            $display("%0t: data expected %h actual %h", $time, want.data, rsp.data);
            errors++;
          end
          if (rsp.level !== want.level) begin
            $display("%0t: level expected %0d actual %0d", $time, want.level, rsp.level);
            errors++;
          end
        end
      end
      rsp_stall <= !quiet_run && ($urandom_range(99) < 15);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("strict_priority_multi_fifo_core: mismatch");
      $finish;
    end
  end

  initial begin
    int i;
    int p;
    int lc_values [8];
    lc_values = '{0, 15, 3, 8, 1, 9, 5, 8};
    for (i = 0; i < NLEV; i++) begin
      head_pos[i] = 0;
      tail_pos[i] = 0;
      fill[i] = 0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // clamp from the top, highest level, zero word, order of pops, empty pop
    pending_reqs.push_back(make_push(255, 32'hFFFF_FFFF));
    pending_reqs.push_back(make_push(0, 32'h0000_0001));
    pending_reqs.push_back(make_push(0, 32'h0));
    pending_reqs.push_back(make_pop());
    pending_reqs.push_back(make_pop());
    pending_reqs.push_back(make_pop());
    // fill one level, then overflow, then zero word on a full level
    for (i = 0; i < DEPTH; i++)
      pending_reqs.push_back(make_push(4, $urandom() | 32'h8000_0000));
    pending_reqs.push_back(make_push(4, 32'h1234_5678));
    pending_reqs.push_back(make_push(4, 32'h0));
    wait_drained();

    for (p = 0; p < 8; p++) begin
      quiet_run = (p == 3);
      pending_level_writes.push_back(LC_W'(lc_values[p]));
      wait_drained();
      queue_random(115);
      wait_drained();
    end
    quiet_run = 1'b0;

    repeat (8) @(negedge clk);
    if (errors == 0 && expected_rsp.size() == 0) begin
      $display("strict_priority_multi_fifo_core: match");
    end else begin
      $display("strict_priority_multi_fifo_core: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/spmf_pkg.sv
rtl/spmf_ctrl.sv
rtl/spmf_dp.sv
rtl/strict_priority_multi_fifo_core.sv
tb/strict_priority_multi_fifo_core_test.sv
